// ===== src/cmcd_pkg.sv =====
// Shared constants, types and helpers for the charge deposit core.
package cmcd_pkg;

    localparam int NUM_MODES   = 4;
    localparam int GRID_Z      = 64;
    localparam int GRID_R      = 32;
    localparam int STORE_DEPTH = NUM_MODES * GRID_Z * GRID_R;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MODE_W      = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
    localparam int DATA_W      = 32;

    localparam int DIV_N = 54;
    localparam int DIV_D = 24;
    localparam int SQ_N  = 48;
    localparam int SQ_R  = 24;

    localparam logic [23:0] RATIO_RESET = 24'd65536;

    localparam logic [1:0] CMD_DEPOSIT = 2'd0;
    localparam logic [1:0] CMD_CLEAR   = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    typedef logic signed [33:0] t_share;
    typedef logic signed [31:0] t_harm;

    typedef struct packed {
        t_share [3:0]           share;
        t_share [1:0]           share15;
        t_harm  [NUM_MODES-1:0] cs;
        t_harm  [NUM_MODES-1:0] sn;
    } t_dep;

    function automatic logic [ADDR_W-1:0] store_addr(input int m, input int z, input int r);
        return ADDR_W'((m * GRID_Z + z) * GRID_R + r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

endpackage

// ===== src/cmcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cmcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/cmcd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module cmcd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [cmcd_pkg::DIV_N-1:0] i_dividend,
    input  logic [cmcd_pkg::DIV_D-1:0] i_divisor,
    output logic                      o_done,
    output logic [cmcd_pkg::DIV_N-1:0] o_quotient
);

    localparam int N  = cmcd_pkg::DIV_N;
    localparam int D  = cmcd_pkg::DIV_D;
    localparam int CW = $clog2(N);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_q;
    logic [D-1:0]  r_rem;
    logic [D-1:0]  r_dvs;
    logic [D:0]    rem_sh;
    logic [D+1:0]  trial;

    always_comb begin
        rem_sh = {r_rem, r_q[N-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(N - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (!trial[D+1]) begin
                    r_rem <= trial[D-1:0];
                    r_q   <= {r_q[N-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[D-1:0];
                    r_q   <= {r_q[N-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(N - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== src/cmcd_sqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
module cmcd_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [cmcd_pkg::SQ_N-1:0] i_radicand,
    output logic                     o_done,
    output logic [cmcd_pkg::SQ_R-1:0] o_root
);

    localparam int N  = cmcd_pkg::SQ_N;
    localparam int R  = cmcd_pkg::SQ_R;
    localparam int RW = R + 2;
    localparam int CW = $clog2(R);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [N-1:0]  r_rad;
    logic [RW-1:0] r_rem;
    logic [R-1:0]  r_root;
    logic [RW+1:0] rem_sh;
    logic [RW+1:0] sub;
    logic [RW+2:0] trial;

    always_comb begin
        rem_sh = {r_rem, r_rad[N-1:N-2]};
        sub    = {2'b00, r_root, 2'b01};
        trial  = {1'b0, rem_sh} - {1'b0, sub};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(R - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_rad  <= i_radicand;
            end else if (r_busy) begin
                r_rad <= {r_rad[N-3:0], 2'b00};
                if (!trial[RW+2]) begin
                    r_rem  <= trial[RW-1:0];
                    r_root <= {r_root[R-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh[RW-1:0];
                    r_root <= {r_root[R-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(R - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== src/cmcd_calc.sv =====
// Deposit front end: charge scaling, radial and axial weights, harmonics, cell shares.
module cmcd_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [4:0]         i_cell_r,
    input  logic [15:0]        i_pos_z_frac,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [31:0] i_charge_weight,
    input  logic [23:0]        i_density_ratio,
    output logic               o_done,
    output cmcd_pkg::t_dep     o_dep
);

    localparam int NM = cmcd_pkg::NUM_MODES;
    localparam int MW = cmcd_pkg::MODE_W;

    typedef enum logic [4:0] {
        S_IDLE, S_MW, S_SX, S_SY, S_R2, S_FGO, S_FWT, S_WGO, S_WWT, S_QGO, S_QWT,
        S_CGO, S_CWT, S_SGO, S_SWT, S_HST, S_H1, S_H2, S_H3, S_H4, S_H5,
        S_A1, S_A2, S_A3, S_DONE
    } t_state;

    t_state                    r_state;
    logic [4:0]                r_cr;
    logic [15:0]               r_zf;
    logic signed [23:0]        r_sx;
    logic signed [23:0]        r_sy;
    logic signed [31:0]        r_q;
    logic [23:0]               r_dr;
    logic signed [65:0]        r_prod;
    logic signed [65:0]        r_acc;
    logic signed [31:0]        r_w;
    logic [47:0]               r_r2;
    logic signed [31:0]        r_factor;
    logic [16:0]               r_wr0;
    logic [23:0]               r_rr;
    cmcd_pkg::t_harm           r_c1, r_s1, r_c, r_s, r_cn;
    logic [MW-1:0]             r_m;
    logic [1:0]                r_k;
    cmcd_pkg::t_share [3:0]    r_share;
    cmcd_pkg::t_share [1:0]    r_share15;
    cmcd_pkg::t_harm [NM-1:0]  r_cs;
    cmcd_pkg::t_harm [NM-1:0]  r_sn;

    logic signed [33:0]             mul_a;
    logic signed [31:0]             mul_b;
    logic signed [65:0]             w_rnd;
    logic [31:0]                    abs_w;
    logic [23:0]                    abs_sx, abs_sy;
    logic [5:0]                     cr1;
    logic [10:0]                    sq;
    logic [5:0]                     denom;
    logic signed [49:0]             num;
    logic                           div_start;
    logic [cmcd_pkg::DIV_N-1:0]     div_dividend;
    logic [cmcd_pkg::DIV_D-1:0]     div_divisor;
    logic                           div_done;
    logic [cmcd_pkg::DIV_N-1:0]     div_q;
    logic                           sq_done;
    logic [cmcd_pkg::SQ_R-1:0]      sq_root;
    logic [32:0]                    wr0c;
    logic [16:0]                    wr0_rnd;
    logic [30:0]                    hmag;
    logic [16:0]                    wr_j, wz_i, a_val;
    logic signed [65:0]             p3;

    function automatic cmcd_pkg::t_harm rnd30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = (v + 66'sd536870912) >>> 30;
        if (t > 66'sd1073741824) begin
            return 32'sd1073741824;
        end else if (t < -66'sd1073741824) begin
            return -32'sd1073741824;
        end
        return 32'(t);
    endfunction

    always_comb begin
        w_rnd   = (r_prod + 66'sd32768) >>> 16;
        abs_w   = r_w[31] ? 32'(-r_w) : 32'(r_w);
        abs_sx  = r_sx[23] ? 24'(-r_sx) : 24'(r_sx);
        abs_sy  = r_sy[23] ? 24'(-r_sy) : 24'(r_sy);
        cr1     = {1'b0, r_cr} + 6'd1;
        sq      = 11'(cr1 * cr1);
        denom   = {r_cr, 1'b1};
        num     = $signed({7'b0, sq, 32'b0}) - $signed({2'b0, r_r2});
        wr0c    = (div_q > 54'h1_0000_0000) ? 33'h1_0000_0000 : div_q[32:0];
        wr0_rnd = 17'((34'(wr0c) + 34'd32768) >> 16);
        hmag    = (div_q > 54'd1073741824) ? 31'd1073741824 : div_q[30:0];
        wr_j    = r_k[0] ? (17'd65536 - r_wr0) : r_wr0;
        wz_i    = r_k[1] ? {1'b0, r_zf} : (17'd65536 - {1'b0, r_zf});
        a_val   = 17'((r_prod + 66'sd32768) >>> 16);
        p3      = r_prod + (r_prod <<< 1);

        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MW: begin
                mul_a = 34'(r_q);
                mul_b = $signed({8'b0, r_dr});
            end
            S_SX: begin
                mul_a = 34'(r_sx);
                mul_b = 32'(r_sx);
            end
            S_SY: begin
                mul_a = 34'(r_sy);
                mul_b = 32'(r_sy);
            end
            S_H1: begin
                mul_a = 34'(r_c);
                mul_b = r_c1;
            end
            S_H2: begin
                mul_a = 34'(r_s);
                mul_b = r_s1;
            end
            S_H3: begin
                mul_a = 34'(r_s);
                mul_b = r_c1;
            end
            S_H4: begin
                mul_a = 34'(r_c);
                mul_b = r_s1;
            end
            S_A1: begin
                mul_a = $signed({17'b0, wr_j});
                mul_b = $signed({15'b0, wz_i});
            end
            S_A2: begin
                mul_a = $signed({17'b0, a_val});
                mul_b = r_factor;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (r_state)
            S_FGO: begin
                div_start    = 1'b1;
                div_dividend = 54'(abs_w);
                div_divisor  = 24'(denom);
            end
            S_WGO: begin
                div_start    = (num > 50'sd0);
                div_dividend = 54'(num[42:0]);
                div_divisor  = 24'(denom);
            end
            S_CGO: begin
                div_start    = 1'b1;
                div_dividend = {abs_sx, 30'b0};
                div_divisor  = r_rr;
            end
            S_SGO: begin
                div_start    = 1'b1;
                div_dividend = {abs_sy, 30'b0};
                div_divisor  = r_rr;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    cmcd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    cmcd_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_QGO),
        .i_radicand (r_r2),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_m     <= '0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cr    <= i_cell_r;
                        r_zf    <= i_pos_z_frac;
                        r_sx    <= i_pos_x;
                        r_sy    <= i_pos_y;
                        r_q     <= i_charge_weight;
                        r_dr    <= i_density_ratio;
                        r_state <= S_MW;
                    end
                end
                S_MW: r_state <= S_SX;
                S_SX: begin
                    r_w     <= cmcd_pkg::sat32(w_rnd);
                    r_state <= S_SY;
                end
                S_SY: begin
                    r_r2    <= 48'(r_prod);
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_r2    <= r_r2 + 48'(r_prod);
                    r_state <= S_FGO;
                end
                S_FGO: r_state <= S_FWT;
                S_FWT: begin
                    if (div_done) begin
                        r_factor <= r_w[31] ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
                        r_state  <= S_WGO;
                    end
                end
                S_WGO: begin
                    if (num > 50'sd0) begin
                        r_state <= S_WWT;
                    end else begin
                        r_wr0   <= '0;
                        r_state <= S_QGO;
                    end
                end
                S_WWT: begin
                    if (div_done) begin
                        r_wr0   <= wr0_rnd;
                        r_state <= S_QGO;
                    end
                end
                S_QGO: r_state <= S_QWT;
                S_QWT: begin
                    if (sq_done) begin
                        r_rr <= sq_root;
                        if (sq_root == '0) begin
                            r_c1    <= '0;
                            r_s1    <= '0;
                            r_state <= S_HST;
                        end else begin
                            r_state <= S_CGO;
                        end
                    end
                end
                S_CGO: r_state <= S_CWT;
                S_CWT: begin
                    if (div_done) begin
                        r_c1    <= r_sx[23] ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
                        r_state <= S_SGO;
                    end
                end
                S_SGO: r_state <= S_SWT;
                S_SWT: begin
                    if (div_done) begin
                        r_s1    <= r_sy[23] ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
                        r_state <= S_HST;
                    end
                end
                S_HST: begin
                    r_c     <= r_c1;
                    r_s     <= r_s1;
                    r_cs[0] <= '0;
                    r_sn[0] <= '0;
                    if (NM > 1) begin
                        r_cs[MW'(1)] <= r_c1;
                        r_sn[MW'(1)] <= r_s1;
                    end
                    r_m <= MW'(2);
                    r_k <= '0;
                    r_state <= (NM > 2) ? S_H1 : S_A1;
                end
                S_H1: r_state <= S_H2;
                S_H2: begin
                    r_acc   <= r_prod;
                    r_state <= S_H3;
                end
                S_H3: begin
                    r_cn    <= rnd30(r_acc - r_prod);
                    r_state <= S_H4;
                end
                S_H4: begin
                    r_acc   <= r_prod;
                    r_state <= S_H5;
                end
                S_H5: begin
                    r_cs[r_m] <= r_cn;
                    r_sn[r_m] <= rnd30(r_acc + r_prod);
                    r_c       <= r_cn;
                    r_s       <= rnd30(r_acc + r_prod);
                    if (r_m == MW'(NM - 1)) begin
                        r_state <= S_A1;
                    end else begin
                        r_m     <= r_m + 1'b1;
                        r_state <= S_H1;
                    end
                end
                S_A1: r_state <= S_A2;
                S_A2: r_state <= S_A3;
                S_A3: begin
                    r_share[r_k] <= 34'((r_prod + 66'sd32768) >>> 16);
                    if (!r_k[0]) begin
                        r_share15[r_k[1]] <= 34'((p3 + 66'sd65536) >>> 17);
                    end
                    if (r_k == 2'd3) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_A1;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done        = (r_state == S_DONE);
    assign o_dep.share   = r_share;
    assign o_dep.share15 = r_share15;
    assign o_dep.cs      = r_cs;
    assign o_dep.sn      = r_sn;

endmodule

// ===== src/cylindrical_mode_charge_deposit_core.sv =====
// Top level: command sequencer, density stores and read-modify-write update loop.
//
//  channel   signals                               direction
//  command   i_valid / o_ready, i_command..        in
//  result    o_valid / i_ready, o_density_*        out
//  config    i_cfg_valid / o_cfg_ready, ratio      in
//
// A deposit runs up to four divisions in one shared divider, a square root,
// the harmonic recurrence and, per (cell, mode), a store update in the states
// S_SEL, S_MC, S_MS and S_WR through the one read and one write RAM port.
// A read passes through S_RWAIT and S_ROUT; the result waits in an output register.
// After reset and on a clear command every store address is swept while no
// command is accepted; configuration writes are always taken.
module cylindrical_mode_charge_deposit_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic [5:0]         i_cell_z,
    input  logic [4:0]         i_cell_r,
    input  logic [1:0]         i_mode_index,
    input  logic [15:0]        i_pos_z_frac,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [31:0] i_charge_weight,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_density_real,
    output logic signed [31:0] o_density_imag,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [23:0]        i_density_ratio
);

    localparam int NM = cmcd_pkg::NUM_MODES;
    localparam int MW = cmcd_pkg::MODE_W;
    localparam int AW = cmcd_pkg::ADDR_W;
    localparam int DW = cmcd_pkg::DATA_W;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_CALC, S_SEL, S_MC, S_MS, S_WR, S_RWAIT, S_ROUT
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_clr;
    logic [23:0]         r_ratio;
    logic [5:0]          r_cz;
    logic [4:0]          r_cr;
    logic [1:0]          r_k;
    logic [MW-1:0]       r_m;
    logic [AW-1:0]       r_addr;
    logic                r_rd_zero;
    logic signed [64:0]  r_pc;
    logic signed [64:0]  r_ps;
    logic                r_ovalid;
    logic signed [31:0]  r_oreal;
    logic signed [31:0]  r_oimag;

    logic                accept;
    logic                calc_done;
    cmcd_pkg::t_dep      dep;
    logic [6:0]          z7;
    logic [5:0]          r6;
    logic                axis;
    logic                sel_ok;
    logic                last;
    logic [AW-1:0]       sel_addr;
    logic                rd_in_range;
    logic signed [33:0]  share_k;
    logic signed [31:0]  mul_h;
    logic signed [35:0]  d_c, d_s, d_real, d_imag;
    logic signed [DW-1:0] rd_real, rd_imag;
    logic signed [DW-1:0] new_real, new_imag;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [DW-1:0]       wd_real, wd_imag;

    always_comb begin
        accept      = i_valid && (r_state == S_IDLE);
        z7          = {1'b0, r_cz} + 7'(r_k[1]);
        r6          = {1'b0, r_cr} + 6'(r_k[0]);
        axis        = (r_cr == '0);
        sel_ok      = (int'(z7) < cmcd_pkg::GRID_Z) && (int'(r6) < cmcd_pkg::GRID_R) &&
                      !(axis && !r_k[0] && (r_m != '0));
        last        = (r_k == 2'd3) && (r_m == MW'(NM - 1));
        sel_addr    = cmcd_pkg::store_addr(int'(r_m), int'(z7), int'(r6));
        rd_in_range = (int'(i_mode_index) < NM) && (int'(i_cell_z) < cmcd_pkg::GRID_Z) &&
                      (int'(i_cell_r) < cmcd_pkg::GRID_R);
        share_k     = dep.share[r_k];
        mul_h       = (r_state == S_MC) ? dep.cs[r_m] : dep.sn[r_m];
        d_c         = 36'((r_pc + 65'sd268435456) >>> 29);
        d_s         = 36'((r_ps + 65'sd268435456) >>> 29);
        if (r_m == '0) begin
            d_real = (axis && !r_k[0]) ? 36'(dep.share15[r_k[1]]) : 36'(share_k);
            d_imag = '0;
        end else begin
            d_real = d_c;
            d_imag = -d_s;
        end
        new_real = cmcd_pkg::sat32(66'(rd_real) + 66'(d_real));
        new_imag = cmcd_pkg::sat32(66'(rd_imag) + 66'(d_imag));
        we       = (r_state == S_CLR) || (r_state == S_WR);
        waddr    = (r_state == S_CLR) ? r_clr : r_addr;
        wd_real  = (r_state == S_CLR) ? '0 : new_real;
        wd_imag  = (r_state == S_CLR) ? '0 : new_imag;
    end

    cmcd_calc u_calc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (accept && (i_command == cmcd_pkg::CMD_DEPOSIT)),
        .i_cell_r        (i_cell_r),
        .i_pos_z_frac    (i_pos_z_frac),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_charge_weight (i_charge_weight),
        .i_density_ratio (r_ratio),
        .o_done          (calc_done),
        .o_dep           (dep)
    );

    cmcd_ram #(.WIDTH(DW), .DEPTH(cmcd_pkg::STORE_DEPTH)) u_ram_real (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wd_real),
        .i_raddr (r_addr),
        .o_rdata (rd_real)
    );

    cmcd_ram #(.WIDTH(DW), .DEPTH(cmcd_pkg::STORE_DEPTH)) u_ram_imag (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wd_imag),
        .i_raddr (r_addr),
        .o_rdata (rd_imag)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_MC) begin
            r_pc <= share_k * mul_h;
        end
        if (r_state == S_MS) begin
            r_ps <= share_k * mul_h;
        end
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ratio  <= cmcd_pkg::RATIO_RESET;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_m      <= '0;
            r_addr   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_ratio <= i_density_ratio;
            end
            if (r_ovalid && i_ready && (r_state != S_ROUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(cmcd_pkg::STORE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_command)
                            cmcd_pkg::CMD_DEPOSIT: begin
                                r_cz    <= i_cell_z;
                                r_cr    <= i_cell_r;
                                r_state <= S_CALC;
                            end
                            cmcd_pkg::CMD_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLR;
                            end
                            cmcd_pkg::CMD_READ: begin
                                r_addr    <= rd_in_range ?
                                             cmcd_pkg::store_addr(int'(i_mode_index),
                                                                  int'(i_cell_z),
                                                                  int'(i_cell_r)) : '0;
                                r_rd_zero <= !rd_in_range;
                                r_state   <= S_RWAIT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CALC: begin
                    if (calc_done) begin
                        r_k     <= '0;
                        r_m     <= '0;
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (sel_ok) begin
                        r_addr  <= sel_addr;
                        r_state <= S_MC;
                    end else if (last) begin
                        r_state <= S_IDLE;
                    end else if (r_m == MW'(NM - 1)) begin
                        r_m <= '0;
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_m <= r_m + 1'b1;
                    end
                end
                S_MC: r_state <= S_MS;
                S_MS: r_state <= S_WR;
                S_WR: begin
                    if (last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SEL;
                        if (r_m == MW'(NM - 1)) begin
                            r_m <= '0;
                            r_k <= r_k + 1'b1;
                        end else begin
                            r_m <= r_m + 1'b1;
                        end
                    end
                end
                S_RWAIT: r_state <= S_ROUT;
                S_ROUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_oreal  <= r_rd_zero ? '0 : rd_real;
                        r_oimag  <= r_rd_zero ? '0 : rd_imag;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_ovalid;
    assign o_density_real = r_oreal;
    assign o_density_imag = r_oimag;

endmodule
